@@ hdl/eul2q_pkg.sv @@
// ============================================================================
// eul2q_pkg
// Types, constants and helpers shared by the Euler angle to quaternion blocks.
// ============================================================================
package eul2q_pkg;

   typedef struct packed {
      logic signed [15:0] roll_angle;
      logic signed [15:0] pitch_angle;
      logic signed [15:0] yaw_angle;
   } eul2q_req_type;

   typedef struct packed {
      logic signed [15:0] quat_w;
      logic signed [15:0] quat_x;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_z;
   } eul2q_rsp_type;

   // cordic in q1.30, phase is a binary angle where a full turn is 2^32
   localparam int CORDIC_STEPS = 30;
   localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;

   localparam logic signed [31:0] ATAN_TABLE [CORDIC_STEPS] = '{
      32'sh20000000, 32'sh12E4051E, 32'sh09FB385B, 32'sh051111D4, 32'sh028B0D43,
      32'sh0145D7E1, 32'sh00A2F61E, 32'sh00517C55, 32'sh0028BE53, 32'sh00145F2F,
      32'sh000A2F98, 32'sh000517CC, 32'sh00028BE6, 32'sh000145F3, 32'sh0000A2FA,
      32'sh0000517D, 32'sh000028BE, 32'sh0000145F, 32'sh00000A30, 32'sh00000518,
      32'sh0000028C, 32'sh00000146, 32'sh000000A3, 32'sh00000051, 32'sh00000029,
      32'sh00000014, 32'sh0000000A, 32'sh00000005, 32'sh00000003, 32'sh00000001
   };

   // degrees to phase: 360 = 8 * 45, division by 45 through a reciprocal
   localparam int DIV_BASE = 45;
   localparam int DIV_SHIFT = 22;
   localparam logic [16:0] DIV_RECIP = 17'd93207;
   localparam int PHASE_BIAS = 22;

   // register stages from angle to cosine/sine, and after it to the result
   localparam int TRIG_LATENCY = 38;
   localparam int MATH_STAGES = 7;

   // round a q2.60 product back to q1.30
   function automatic logic signed [31:0] q30_round(input logic signed [63:0] prod);
      logic signed [63:0] biased;
      biased = prod + 64'sd536870912;
      return biased[61:30];
   endfunction

endpackage

@@ hdl/euler_to_quaternion_unit.sv @@
// ============================================================================
// euler_to_quaternion_unit
// Roll, pitch and yaw in degrees to the unit quaternion, ZYX convention.
// ============================================================================
// Usage:
//   req channel carries roll, pitch and yaw (signed degrees, ANGLE_FRAC_BITS
//   fraction bits); rsp channel returns w, x, y, z rounded and saturated to
//   +-1.0 with OUT_FRAC_BITS fraction bits. Each request gives one response.
//   Path from the request transfer to rsp_valid: 38 stages of half angle
//   sine/cosine (phase scaling, quadrant fold, 30 cordic steps), 7 stages
//   of products, sums and output rounding, then the output register.
//   Throughput: one item per cycle; every pipeline stage takes a new item
//   each clock while the output side keeps up.
//   Stall: a two-entry output buffer (rsp register plus skid register) lets
//   the pipeline take one more item while a response waits; once the skid
//   entry is full the whole pipeline holds and req_ready is low. req_ready
//   comes from a register only.
//   Reset clears every stage valid bit and both output entries; items in
//   flight are dropped. There is no configuration and no kept state.
// ============================================================================
module euler_to_quaternion_unit #(
   parameter int ANGLE_FRAC_BITS = 7,
   parameter int OUT_FRAC_BITS = 14
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  eul2q_pkg::eul2q_req_type req_payload,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output eul2q_pkg::eul2q_rsp_type rsp_payload
);
   import eul2q_pkg::*;

   localparam int PIPE_DEPTH = TRIG_LATENCY + MATH_STAGES;
   localparam int OUT_SHIFT = 30 - OUT_FRAC_BITS;
   localparam logic signed [33:0] OUT_RND = 34'((64'd1 << OUT_SHIFT) >> 1);
   localparam logic signed [33:0] SAT_ONE = 34'sd1 <<< OUT_FRAC_BITS;
   localparam logic signed [33:0] MAX16 = 34'sd32767;
   localparam logic signed [33:0] MIN16 = -34'sd32768;
   localparam logic signed [15:0] OUT_HI =
      (OUT_FRAC_BITS < 15) ? 16'(1 << OUT_FRAC_BITS) : 16'sh7FFF;
   localparam logic signed [15:0] OUT_LO =
      (OUT_FRAC_BITS < 15) ? 16'(-(1 << OUT_FRAC_BITS)) : 16'sh8000;

   logic adv;
   logic [PIPE_DEPTH-1:0] vld_ff, vld_in;

   logic signed [31:0] roll_cos, roll_sin, pitch_cos, pitch_sin, yaw_cos, yaw_sin;

   // pair order: cr*cp, sr*cp, cr*sp, sr*sp
   logic signed [63:0] pair_prod_ff [4];
   logic signed [31:0] pair_ff [4];
   logic signed [31:0] yc_ff [2];
   logic signed [31:0] ys_ff [2];
   // lane order w, x, y, z; term a and term b of each lane
   logic signed [63:0] ta_prod_in [4], ta_prod_ff [4];
   logic signed [63:0] tb_prod_in [4], tb_prod_ff [4];
   logic signed [31:0] ta_ff [4], tb_ff [4];
   logic signed [32:0] sum_in [4], sum_ff [4];
   logic signed [33:0] rnd_ff [4];
   logic signed [33:0] shifted [4];
   logic signed [33:0] clipped [4];
   logic signed [15:0] lane_out [4];
   eul2q_rsp_type      res_ff, res_in;

   // output buffer
   logic          push, pop;
   logic          rsp_valid_ff, rsp_valid_in, skid_valid_ff, skid_valid_in;
   eul2q_rsp_type rsp_data_ff, rsp_data_in, skid_data_ff, skid_data_in;

   assign adv = ~skid_valid_ff;
   assign req_ready = adv;
   assign vld_in = {vld_ff[PIPE_DEPTH-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   eul2q_trig #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_roll (
      .clock(clock), .adv(adv), .angle(req_payload.roll_angle),
      .cos_out(roll_cos), .sin_out(roll_sin)
   );
   eul2q_trig #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_pitch (
      .clock(clock), .adv(adv), .angle(req_payload.pitch_angle),
      .cos_out(pitch_cos), .sin_out(pitch_sin)
   );
   eul2q_trig #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_yaw (
      .clock(clock), .adv(adv), .angle(req_payload.yaw_angle),
      .cos_out(yaw_cos), .sin_out(yaw_sin)
   );

   always_comb begin
      ta_prod_in[0] = pair_ff[0] * yc_ff[1];
      tb_prod_in[0] = pair_ff[3] * ys_ff[1];
      ta_prod_in[1] = pair_ff[1] * yc_ff[1];
      tb_prod_in[1] = pair_ff[2] * ys_ff[1];
      ta_prod_in[2] = pair_ff[2] * yc_ff[1];
      tb_prod_in[2] = pair_ff[1] * ys_ff[1];
      ta_prod_in[3] = pair_ff[0] * ys_ff[1];
      tb_prod_in[3] = pair_ff[3] * yc_ff[1];
      for (int k = 0; k < 4; k++) begin
         // x and z take the difference
         if (k == 1 || k == 3) begin
            sum_in[k] = 33'(ta_ff[k]) - 33'(tb_ff[k]);
         end else begin
            sum_in[k] = 33'(ta_ff[k]) + 33'(tb_ff[k]);
         end
         shifted[k] = rnd_ff[k] >>> OUT_SHIFT;
         if (shifted[k] > SAT_ONE) begin
            clipped[k] = SAT_ONE;
         end else if (shifted[k] < -SAT_ONE) begin
            clipped[k] = -SAT_ONE;
         end else begin
            clipped[k] = shifted[k];
         end
         if (clipped[k] > MAX16) begin
            lane_out[k] = 16'sh7FFF;
         end else if (clipped[k] < MIN16) begin
            lane_out[k] = 16'sh8000;
         end else begin
            lane_out[k] = clipped[k][15:0];
         end
      end
      res_in.quat_w = lane_out[0];
      res_in.quat_x = lane_out[1];
      res_in.quat_y = lane_out[2];
      res_in.quat_z = lane_out[3];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pair_prod_ff[0] <= roll_cos * pitch_cos;
         pair_prod_ff[1] <= roll_sin * pitch_cos;
         pair_prod_ff[2] <= roll_cos * pitch_sin;
         pair_prod_ff[3] <= roll_sin * pitch_sin;
         yc_ff[0] <= yaw_cos;
         ys_ff[0] <= yaw_sin;
         for (int k = 0; k < 4; k++) begin
            pair_ff[k] <= q30_round(pair_prod_ff[k]);
            ta_prod_ff[k] <= ta_prod_in[k];
            tb_prod_ff[k] <= tb_prod_in[k];
            ta_ff[k] <= q30_round(ta_prod_ff[k]);
            tb_ff[k] <= q30_round(tb_prod_ff[k]);
            sum_ff[k] <= sum_in[k];
            rnd_ff[k] <= 34'(sum_ff[k]) + OUT_RND;
         end
         yc_ff[1] <= yc_ff[0];
         ys_ff[1] <= ys_ff[0];
         res_ff <= res_in;
      end
   end

   // two-entry output buffer
   assign push = adv & vld_ff[PIPE_DEPTH-1];
   assign pop = rsp_valid_ff & rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in = skid_data_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            rsp_data_in = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!rsp_valid_ff || pop) begin
            rsp_data_in = res_ff;
            rsp_valid_in = 1'b1;
         end else begin
            skid_data_in = res_ff;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

`ifndef SYNTHESIS
   // a waiting skid entry always sits behind a valid response
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry valid without a response in the output register");

   // a transfer out of a full buffer moves the skid entry forward
   assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && rsp_ready) |=> (rsp_valid_ff && !skid_valid_ff))
      else $error("skid entry not moved forward after an output transfer");

   // every part of the result stays within plus or minus one
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |->
         (rsp_payload.quat_w <= OUT_HI && rsp_payload.quat_w >= OUT_LO &&
          rsp_payload.quat_x <= OUT_HI && rsp_payload.quat_x >= OUT_LO &&
          rsp_payload.quat_y <= OUT_HI && rsp_payload.quat_y >= OUT_LO &&
          rsp_payload.quat_z <= OUT_HI && rsp_payload.quat_z >= OUT_LO))
      else $error("quaternion part outside the saturation range");
`endif

endmodule

@@ hdl/eul2q_trig.sv @@
// ============================================================================
// eul2q_trig
// Pipelined half angle cosine and sine: degrees to phase, quadrant fold,
// then one cordic rotation step per register stage.
// ============================================================================
module eul2q_trig #(
   parameter int ANGLE_FRAC_BITS = 7
) (
   input  logic               clock,
   input  logic               adv,
   input  logic signed [15:0] angle,
   output logic signed [31:0] cos_out,
   output logic signed [31:0] sin_out
);
   import eul2q_pkg::*;

   localparam int SHIFT_J = 28 - ANGLE_FRAC_BITS;
   localparam int QUO_A = (1 << SHIFT_J) / DIV_BASE;
   localparam int REM_B = (1 << SHIFT_J) % DIV_BASE;
   localparam logic signed [31:0] QUARTER = 32'sh4000_0000;
   localparam logic signed [31:0] NEG_QUARTER = 32'shC000_0000;

   // stage a: magnitude and quotient by 45
   logic [15:0] mag_in, mag_a_ff;
   logic [32:0] recip_prod;
   logic [9:0]  quo_in, quo_a_ff;
   logic        neg_a_ff;
   // stage b: remainder
   logic [5:0]  rem_in, rem_b_ff;
   logic [9:0]  quo_b_ff;
   logic        neg_b_ff;
   // stage c
   logic [10:0] corr_in, corr_c_ff;
   logic [31:0] part_in, part_c_ff;
   logic [9:0]  quo_c_ff;
   logic        neg_c_ff;
   // stage d
   logic [27:0] frac_prod;
   logic [5:0]  tail_in, tail_d_ff;
   logic [31:0] base_in, base_d_ff;
   logic        neg_d_ff;
   // stage e, f
   logic [31:0] q_in, q_e_ff;
   logic        neg_e_ff;
   logic signed [31:0] phase_in, phase_f_ff;
   // cordic
   logic signed [31:0] fold_z_in;
   logic               fold_flip_in;
   logic signed [31:0] cx_ff [0:CORDIC_STEPS];
   logic signed [31:0] cy_ff [0:CORDIC_STEPS];
   logic signed [31:0] cz_ff [0:CORDIC_STEPS];
   logic               cf_ff [0:CORDIC_STEPS];
   logic signed [31:0] cos_in, cos_ff, sin_in, sin_ff;

   always_comb begin
      mag_in = angle[15] ? (16'd0 - $unsigned(angle)) : $unsigned(angle);
      recip_prod = 33'(mag_in) * 33'(DIV_RECIP);
      quo_in = recip_prod[DIV_SHIFT +: 10];
      rem_in = 6'(mag_a_ff - 16'(16'(quo_a_ff) * 16'(DIV_BASE)));
      corr_in = 11'(11'(rem_b_ff) * 11'(REM_B)) + 11'(PHASE_BIAS);
      part_in = 32'(rem_b_ff) * 32'(QUO_A);
      frac_prod = 28'(corr_c_ff) * 28'(DIV_RECIP);
      tail_in = frac_prod[DIV_SHIFT +: 6];
      base_in = (32'(quo_c_ff) << SHIFT_J) + part_c_ff;
      q_in = base_d_ff + 32'(tail_d_ff);
      phase_in = neg_e_ff ? $signed(32'd0 - q_e_ff) : $signed(q_e_ff);
      // beyond a quarter turn: move by a half turn, negate the result later
      if (phase_f_ff > QUARTER || phase_f_ff < NEG_QUARTER) begin
         fold_z_in = {~phase_f_ff[31], phase_f_ff[30:0]};
         fold_flip_in = 1'b1;
      end else begin
         fold_z_in = phase_f_ff;
         fold_flip_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mag_a_ff <= mag_in;
         quo_a_ff <= quo_in;
         neg_a_ff <= angle[15];
         rem_b_ff <= rem_in;
         quo_b_ff <= quo_a_ff;
         neg_b_ff <= neg_a_ff;
         corr_c_ff <= corr_in;
         part_c_ff <= part_in;
         quo_c_ff <= quo_b_ff;
         neg_c_ff <= neg_b_ff;
         tail_d_ff <= tail_in;
         base_d_ff <= base_in;
         neg_d_ff <= neg_c_ff;
         q_e_ff <= q_in;
         neg_e_ff <= neg_d_ff;
         phase_f_ff <= phase_in;
         cx_ff[0] <= CORDIC_GAIN;
         cy_ff[0] <= 32'sd0;
         cz_ff[0] <= fold_z_in;
         cf_ff[0] <= fold_flip_in;
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      logic signed [31:0] cx_in, cy_in, cz_in;

      always_comb begin
         if (cz_ff[i] >= 32'sd0) begin
            cx_in = cx_ff[i] - (cy_ff[i] >>> i);
            cy_in = cy_ff[i] + (cx_ff[i] >>> i);
            cz_in = cz_ff[i] - ATAN_TABLE[i];
         end else begin
            cx_in = cx_ff[i] + (cy_ff[i] >>> i);
            cy_in = cy_ff[i] - (cx_ff[i] >>> i);
            cz_in = cz_ff[i] + ATAN_TABLE[i];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            cx_ff[i+1] <= cx_in;
            cy_ff[i+1] <= cy_in;
            cz_ff[i+1] <= cz_in;
            cf_ff[i+1] <= cf_ff[i];
         end
      end
   end

   always_comb begin
      cos_in = cf_ff[CORDIC_STEPS] ? -cx_ff[CORDIC_STEPS] : cx_ff[CORDIC_STEPS];
      sin_in = cf_ff[CORDIC_STEPS] ? -cy_ff[CORDIC_STEPS] : cy_ff[CORDIC_STEPS];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cos_ff <= cos_in;
         sin_ff <= sin_in;
      end
   end

   assign cos_out = cos_ff;
   assign sin_out = sin_ff;

endmodule
